// ----- sv/int_to_decimal_ascii_defines.svh -----
// Assertion macros used by the checker file.
`ifndef INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define I2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define I2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/i2da_pkg.sv -----
`default_nettype none

package i2da_pkg;

  localparam int NumDigits  = 10;
  localparam int ValueW     = 32;
  localparam int BitsPerCyc = 2;
  localparam int ShiftSteps = ValueW / BitsPerCyc;
  localparam int CntW       = $clog2(ShiftSteps);
  localparam int IdxW       = $clog2(NumDigits);
  localparam int PcW        = 3;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;

  typedef logic [PcW-1:0] pc_t;

  // Program addresses
  localparam pc_t StepIdle   = 3'd0;
  localparam pc_t StepDabble = 3'd1;
  localparam pc_t StepSkip   = 3'd2;
  localparam pc_t StepSign   = 3'd3;
  localparam pc_t StepDigit  = 3'd4;
  localparam pc_t StepDone   = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DABBLE,
    OP_SKIP,
    OP_SIGN,
    OP_DIGIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_SHIFT_MORE,
    C_LEAD_ZERO,
    C_MORE_DIGITS
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic              cmd;
    logic [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } rsp_t;

endpackage

`default_nettype wire

// ----- sv/int_to_decimal_ascii.sv -----
`default_nettype none
// Integer to decimal ASCII converter.
// Request channel: req_i carries cmd (0 unsigned, 1 two's complement signed)
// and a 32-bit value; a request is taken at a clock edge where start is high
// and busy is low. Response channel: rsp_o carries one ASCII byte and a last
// flag, marked by rsp_valid_o for exactly one cycle; the receiver cannot stall,
// so each byte must be taken in the cycle it is shown.
// Output: an optional '-', then 1 to 10 digits, most significant first, with no
// leading zeros; last marks the final digit.
// Sequence: a request keeps busy high through all of its steps, and a new request
// is taken only on an idle step, so one request must finish before the next is
// taken. Busy covers the 16 passes of the two-bit shift-and-add-3 binary to BCD
// converter, one step per decimal position (leading zeros are scanned, digits are
// emitted), one more to stop on the first digit, a sign step and a closing step.
// Once the first byte appears, bytes follow one per cycle.
// Control is a six-word microprogram in a constant table, stepped by a program
// counter with conditional jumps. Reset returns the counter to the idle step
// and drops rsp_valid_o; nothing is kept between requests.
module int_to_decimal_ascii (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire i2da_pkg::req_t req_i,
  output logic               busy,
  output i2da_pkg::rsp_t     rsp_o,
  output logic               rsp_valid_o
);
  import i2da_pkg::*;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      StepIdle:   w = '{op: OP_LOAD,   cond: C_NO_START,    target: StepIdle};
      StepDabble: w = '{op: OP_DABBLE, cond: C_SHIFT_MORE,  target: StepDabble};
      StepSkip:   w = '{op: OP_SKIP,   cond: C_LEAD_ZERO,   target: StepSkip};
      StepSign:   w = '{op: OP_SIGN,   cond: C_NEVER,       target: StepIdle};
      StepDigit:  w = '{op: OP_DIGIT,  cond: C_MORE_DIGITS, target: StepDigit};
      StepDone:   w = '{op: OP_NOP,    cond: C_ALWAYS,      target: StepIdle};
      default:    w = '{op: OP_NOP,    cond: C_ALWAYS,      target: StepIdle};
    endcase
    return w;
  endfunction

  pc_t                         pc_q, pc_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [NumDigits-1:0][3:0]   bcd_q, bcd_d;
  logic [ValueW-1:0]           bin_q, bin_d;
  logic                        neg_q, neg_d;
  rsp_t                        rsp_q, rsp_d;
  logic                        rsp_valid_q, rsp_valid_d;

  ucode_t                      uw;
  logic                        taken;
  logic                        req_neg;
  logic [ValueW-1:0]           req_mag;
  logic [3:0]                  cur_digit;

  assign uw        = ucode_rom(pc_q);
  assign req_neg   = req_i.cmd & req_i.value[ValueW-1];
  assign req_mag   = req_neg ? (~req_i.value + ValueW'(1)) : req_i.value;
  assign cur_digit = bcd_q[idx_q];

  // Branch condition
  always_comb begin
    case (uw.cond)
      C_NEVER:       taken = 1'b0;
      C_ALWAYS:      taken = 1'b1;
      C_NO_START:    taken = !start;
      C_SHIFT_MORE:  taken = (cnt_q != CntW'(ShiftSteps - 1));
      C_LEAD_ZERO:   taken = (cur_digit == 4'd0) && (idx_q != '0);
      C_MORE_DIGITS: taken = (idx_q != '0);
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = taken ? uw.target : pc_q + pc_t'(1);
  end

  // Datapath driven by the current control word
  always_comb begin
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    bcd_d       = bcd_q;
    bin_d       = bin_q;
    neg_d       = neg_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    case (uw.op)
      OP_LOAD: begin
        cnt_d = '0;
        idx_d = IdxW'(NumDigits - 1);
        bcd_d = '0;
        bin_d = req_mag;
        neg_d = req_neg;
      end
      OP_DABBLE: begin
        for (int s = 0; s < BitsPerCyc; s++) begin
          for (int d = 0; d < NumDigits; d++) begin
            if (bcd_d[d] >= 4'd5) begin
              bcd_d[d] = bcd_d[d] + 4'd3;
            end
          end
          {bcd_d, bin_d} = {bcd_d, bin_d} << 1;
        end
        cnt_d = cnt_q + CntW'(1);
      end
      OP_SKIP: begin
        if (taken) begin
          idx_d = idx_q - IdxW'(1);
        end
      end
      OP_SIGN: begin
        rsp_valid_d   = neg_q;
        rsp_d.char_out = CharMinus;
        rsp_d.last     = 1'b0;
      end
      OP_DIGIT: begin
        rsp_valid_d    = 1'b1;
        rsp_d.char_out = CharZero + {4'b0000, cur_digit};
        rsp_d.last     = (idx_q == '0);
        idx_d          = idx_q - IdxW'(1);
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StepIdle;
      rsp_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    idx_q <= idx_d;
    bcd_q <= bcd_d;
    bin_q <= bin_d;
    neg_q <= neg_d;
    rsp_q <= rsp_d;
  end

  assign busy        = (pc_q != StepIdle);
  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

`default_nettype wire

// ----- sv/i2da_checker.sv -----
`default_nettype none
`include "int_to_decimal_ascii_defines.svh"

module i2da_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire i2da_pkg::rsp_t rsp_o,
  input wire logic           rsp_valid_o
);
  import i2da_pkg::*;

  logic accept;

  assign accept = start && !busy;

  `I2DA_ASSERT_NEXT(a_busy_after_req, accept, busy, "busy not raised after request")
  `I2DA_ASSERT_NEXT(a_no_rsp_after_req, accept, !rsp_valid_o, "response too early")
  `I2DA_ASSERT_NOW(a_rsp_while_busy, rsp_valid_o, busy, "response while idle")
  `I2DA_ASSERT_NEXT(a_gap_after_last, rsp_valid_o && rsp_o.last, !rsp_valid_o, "byte after last")
  `I2DA_ASSERT_NOW(a_sign_not_last, rsp_valid_o && (rsp_o.char_out == CharMinus), !rsp_o.last, "sign marked last")

endmodule

bind int_to_decimal_ascii i2da_checker u_i2da_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2da_pkg::*;

  localparam int unsigned Pow10 [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
    32'd10000000, 32'd100000000, 32'd1000000000
  };
  localparam int RandomItems = 250;
  localparam int DrainCycles = 40;

  logic clk_i;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  rsp_t rsp_o;
  logic rsp_valid_o;

  // characters still owed by the block, oldest first
  rsp_t char_q[$];
  int   err_cnt = 0;

  int_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Work out the decimal text of one request and queue its characters.
  function automatic void queue_decimal_text(input req_t r);
    logic        neg;
    logic [31:0] mag;
    logic [7:0]  digits [10];
    int          nd;
    rsp_t        c;
    neg = r.cmd && r.value[31];
    mag = neg ? (~r.value + 32'd1) : r.value;
    nd  = 0;
    do begin
      digits[nd] = CharZero + 8'(mag % 32'd10);
      mag = mag / 32'd10;
      nd++;
    end while (mag != 32'd0);
    if (neg) begin
      c.char_out = CharMinus;
      c.last     = 1'b0;
      char_q.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.char_out = digits[i];
      c.last     = (i == 0);
      char_q.push_back(c);
    end
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: w = $urandom;
      1: w = $urandom_range(0, 20);
      2: w = Pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
      3: w = 32'h7FFF_FFF0 + $urandom_range(0, 32);
      4: w = $urandom >> $urandom_range(0, 31);
      default: w = 32'hFFFF_FFFF - $urandom_range(0, 20);
    endcase
    return w;
  endfunction

  // Hold the request until the block takes it, then drop start for one edge.
  task automatic send_number(input logic cmd, input logic [31:0] value);
    req_t r;
    r.cmd   = cmd;
    r.value = value;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    queue_decimal_text(r);
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Idle with start low; scramble the request lines meanwhile.
  task automatic idle_gap(input int n);
    req_t noise;
    repeat (n) begin
      noise.cmd   = $urandom_range(0, 1);
      noise.value = $urandom;
      req_i <= noise;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_zero();
    send_number(1'b0, 32'd0);
    send_number(1'b1, 32'd0);
  endtask

  task automatic test_sign_handling();
    send_number(1'b1, 32'h8000_0000);
    send_number(1'b0, 32'h8000_0000);
    send_number(1'b1, 32'hFFFF_FFFF);
    send_number(1'b0, 32'hFFFF_FFFF);
    send_number(1'b1, 32'h7FFF_FFFF);
    send_number(1'b0, 32'h7FFF_FFFF);
    send_number(1'b1, 32'h8000_0001);
    send_number(1'b1, 32'hFFFF_FFF6);
    send_number(1'b1, 32'd1);
  endtask

  task automatic test_digit_counts();
    send_number(1'b0, 32'd1);
    send_number(1'b0, 32'd9);
    send_number(1'b1, 32'd10);
    send_number(1'b0, 32'd99);
    send_number(1'b1, 32'd100);
    send_number(1'b0, 32'd999_999_999);
    send_number(1'b0, 32'd1_000_000_000);
    send_number(1'b1, 32'd123_456_789);
  endtask

  // Let the block run dry, then start again from idle.
  task automatic test_drain_pause();
    send_number($urandom_range(0, 1), pick_word());
    send_number($urandom_range(0, 1), pick_word());
    wait_drained();
    send_number(1'b1, 32'h8000_0000);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < RandomItems; i++) begin
        send_number($urandom_range(0, 1), pick_word());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 40));
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      if (char_q.size() == 0) begin
        $error("unexpected character: char_out %h last %b", rsp_o.char_out, rsp_o.last);
        err_cnt++;
      end else begin
        rsp_t want;
        want = char_q.pop_front();
        if (rsp_o.char_out !== want.char_out) begin
          $error("char_out: expected %h, got %h", want.char_out, rsp_o.char_out);
          err_cnt++;
        end
        if (rsp_o.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, rsp_o.last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero();
    test_sign_handling();
    test_digit_counts();
    test_drain_pause();
    test_random_traffic();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && char_q.size() == 0) begin
      $display("** int_to_decimal_ascii: PASSED **");
    end else begin
      $display("** int_to_decimal_ascii: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** int_to_decimal_ascii: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/i2da_pkg.sv
sv/int_to_decimal_ascii.sv
sv/i2da_checker.sv
tb/tb_top.sv
